// ===== rtl/core/ata_pkg.sv =====
package ata_pkg;

  // Fraction bits of the output angles, in degrees.
  localparam int ANGLE_FRAC_BITS = 8;
  // Number of CORDIC micro-rotations.
  localparam int CORDIC_STAGES   = 16;

  // Angle accumulator: degrees with 20 fraction bits.
  localparam int ACC_FRAC = 20;
  localparam int ACC_W    = 28;
  // CORDIC x and y datapath width.
  localparam int XY_W     = 35;
  // Radicand (sum of squares), root and numerator widths.
  localparam int RAD_W    = 32;
  localparam int ROOT_W   = 32;
  localparam int NUM_W    = 17;

  localparam logic signed [ACC_W-1:0] ANGLE_FULL = ACC_W'(90 << ANGLE_FRAC_BITS);
  localparam logic signed [ACC_W-1:0] ANGLE_HALF = ACC_W'(1 << (ACC_FRAC - 1 - ANGLE_FRAC_BITS));
  localparam logic signed [ACC_W-1:0] OUT_MAX    = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] OUT_MIN    = -ACC_W'(32768);

  // atan(2^-i) in degrees, scaled by 2^20 and rounded.
  function automatic logic signed [ACC_W-1:0] atan_entry(input int i);
    logic signed [ACC_W-1:0] e;
    unique case (i)
      0:  e = 28'sd47185920;
      1:  e = 28'sd27855475;
      2:  e = 28'sd14718068;
      3:  e = 28'sd7471121;
      4:  e = 28'sd3750058;
      5:  e = 28'sd1876857;
      6:  e = 28'sd938658;
      7:  e = 28'sd469357;
      8:  e = 28'sd234682;
      9:  e = 28'sd117342;
      10: e = 28'sd58671;
      11: e = 28'sd29335;
      12: e = 28'sd14668;
      13: e = 28'sd7334;
      14: e = 28'sd3667;
      15: e = 28'sd1833;
      16: e = 28'sd917;
      17: e = 28'sd458;
      18: e = 28'sd229;
      19: e = 28'sd115;
      20: e = 28'sd57;
      21: e = 28'sd29;
      22: e = 28'sd14;
      23: e = 28'sd7;
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

// ===== rtl/core/accel_tilt_angles.sv =====
// Roll and pitch from one three-axis accelerometer sample, in degrees with
// ANGLE_FRAC_BITS fraction bits (1/256 degree by default). The axes are
// remapped as forward = Y and lateral = -X. The block is a fully pipelined
// datapath: one sample is accepted every cycle while the output is not
// stalled. Each sample passes through the square and sum registers, the 32
// one-bit stages of the square-root pipeline, the CORDIC micro-rotation
// stages and the output register. The whole pipeline advances together; it
// holds only while a result sits at the output and the sink is not ready.
module accel_tilt_angles (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // roll_angle [15:0], pitch_angle [31:16]
);
  import ata_pkg::*;

  logic en;
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  logic signed [15:0] ax, ay, az;
  assign ax = in_tdata[15:0];
  assign ay = in_tdata[31:16];
  assign az = in_tdata[47:32];

  // Squares of the three axes; lat^2 equals x^2.
  logic              v1_r;
  logic [RAD_W-1:0]  sqx_r, sqy_r, sqz_r;
  logic signed [NUM_W-1:0] lat_r, fwd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
    if (en) begin
      sqx_r <= RAD_W'(RAD_W'(ax) * RAD_W'(ax));
      sqy_r <= RAD_W'(RAD_W'(ay) * RAD_W'(ay));
      sqz_r <= RAD_W'(RAD_W'(az) * RAD_W'(az));
      lat_r <= -NUM_W'(ax);
      fwd_r <= NUM_W'(ay);
    end
  end

  // Sums of squares and numerators for both angles.
  logic                    v2_r;
  logic [RAD_W-1:0]        srol_r, spit_r;
  logic signed [NUM_W-1:0] nrol_r, npit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      srol_r <= RAD_W'(sqy_r + sqz_r);
      spit_r <= RAD_W'(sqx_r + sqz_r);
      nrol_r <= lat_r;
      npit_r <= -fwd_r;
    end
  end

  logic                    rv_s, pv_s;
  logic [ROOT_W-1:0]       rroot, proot;
  logic signed [NUM_W-1:0] rnum, pnum;

  ata_sqrt u_sqrt_roll (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v2_r), .in_rad(srol_r),
    .in_num(nrol_r), .out_valid(rv_s), .out_root(rroot), .out_num(rnum)
  );

  ata_sqrt u_sqrt_pitch (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v2_r), .in_rad(spit_r),
    .in_num(npit_r), .out_valid(pv_s), .out_root(proot), .out_num(pnum)
  );

  logic               rv_c, pv_c;
  logic signed [15:0] roll, pitch;

  ata_cordic u_cordic_roll (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(rv_s), .in_root(rroot),
    .in_num(rnum), .out_valid(rv_c), .out_angle(roll)
  );

  ata_cordic u_cordic_pitch (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(pv_s), .in_root(proot),
    .in_num(pnum), .out_valid(pv_c), .out_angle(pitch)
  );

  // Both lanes run in lockstep, so either valid marks the beat.
  assign out_tvalid = rv_c & pv_c;
  assign out_tdata  = {pitch, roll};

endmodule

// ===== rtl/core/ata_sqrt.sv =====
module ata_sqrt (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [ata_pkg::RAD_W-1:0]          in_rad,
  input  logic signed [ata_pkg::NUM_W-1:0]   in_num,
  output logic                               out_valid,
  output logic [ata_pkg::ROOT_W-1:0]         out_root,
  output logic signed [ata_pkg::NUM_W-1:0]   out_num
);
  import ata_pkg::*;

  // floor(sqrt(rad * 2^32)), one root bit per stage.
  localparam int STEPS = ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic                    v_r    [0:STEPS];
  logic [RAD_W-1:0]        rad_r  [0:STEPS];
  logic [ROOT_W-1:0]       root_r [0:STEPS];
  logic [REM_W-1:0]        rem_r  [0:STEPS];
  logic signed [NUM_W-1:0] num_r  [0:STEPS];

  // Entry register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
    if (en) begin
      rad_r[0]  <= in_rad;
      root_r[0] <= '0;
      rem_r[0]  <= '0;
      num_r[0]  <= in_num;
    end
  end

  genvar k;
  generate
    for (k = 0; k < STEPS; k++) begin : g_step
      localparam int P = STEPS - 1 - k;
      logic [1:0]       pair;
      logic [REM_W+1:0] rem_nxt;
      logic [REM_W+1:0] trial;
      logic             take;

      // The low half of the scaled radicand is all zeros.
      if (P >= RAD_W / 2) begin : g_hi
        assign pair = rad_r[k][2*(P-RAD_W/2)+1 -: 2];
      end else begin : g_lo
        assign pair = 2'b00;
      end

      assign rem_nxt = {rem_r[k], pair};
      assign trial   = {2'b00, root_r[k], 2'b01};
      assign take    = (rem_nxt >= trial);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k+1] <= 1'b0;
        end else if (en) begin
          v_r[k+1] <= v_r[k];
        end
        if (en) begin
          rad_r[k+1]  <= rad_r[k];
          num_r[k+1]  <= num_r[k];
          root_r[k+1] <= {root_r[k][ROOT_W-2:0], take};
          rem_r[k+1]  <= take ? REM_W'(rem_nxt - trial) : REM_W'(rem_nxt);
        end
      end
    end
  endgenerate

  assign out_valid = v_r[STEPS];
  assign out_root  = root_r[STEPS];
  assign out_num   = num_r[STEPS];

endmodule

// ===== rtl/core/ata_cordic.sv =====
module ata_cordic (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [ata_pkg::ROOT_W-1:0]         in_root,
  input  logic signed [ata_pkg::NUM_W-1:0]   in_num,
  output logic                               out_valid,
  output logic signed [15:0]                 out_angle
);
  import ata_pkg::*;

  logic                    v_r    [0:CORDIC_STAGES];
  logic signed [XY_W-1:0]  x_r    [0:CORDIC_STAGES];
  logic signed [XY_W-1:0]  y_r    [0:CORDIC_STAGES];
  logic signed [ACC_W-1:0] acc_r  [0:CORDIC_STAGES];
  logic                    zero_r [0:CORDIC_STAGES];
  logic                    pos_r  [0:CORDIC_STAGES];
  logic                    neg_r  [0:CORDIC_STAGES];

  // Load x with the root and y with the numerator, both with 16 fraction bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
    if (en) begin
      x_r[0]    <= XY_W'(in_root);
      y_r[0]    <= XY_W'(in_num) <<< 16;
      acc_r[0]  <= '0;
      zero_r[0] <= (in_root == '0);
      pos_r[0]  <= (in_num > 0);
      neg_r[0]  <= (in_num < 0);
    end
  end

  // Vectoring micro-rotations toward y = 0.
  genvar i;
  generate
    for (i = 0; i < CORDIC_STAGES; i++) begin : g_rot
      logic signed [XY_W-1:0] dx;
      logic signed [XY_W-1:0] dy;
      assign dx = y_r[i] >>> i;
      assign dy = x_r[i] >>> i;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[i+1] <= 1'b0;
        end else if (en) begin
          v_r[i+1] <= v_r[i];
        end
        if (en) begin
          zero_r[i+1] <= zero_r[i];
          pos_r[i+1]  <= pos_r[i];
          neg_r[i+1]  <= neg_r[i];
          if (!y_r[i][XY_W-1]) begin
            x_r[i+1]   <= x_r[i] + dx;
            y_r[i+1]   <= y_r[i] - dy;
            acc_r[i+1] <= acc_r[i] + atan_entry(i);
          end else begin
            x_r[i+1]   <= x_r[i] - dx;
            y_r[i+1]   <= y_r[i] + dy;
            acc_r[i+1] <= acc_r[i] - atan_entry(i);
          end
        end
      end
    end
  endgenerate

  // Round half up to the output resolution, clamp, and handle a zero root.
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-1:0] clp;
  logic signed [ACC_W-1:0] fin;
  logic                    out_valid_r;
  logic signed [15:0]      angle_r;

  always_comb begin
    rnd = (acc_r[CORDIC_STAGES] + ANGLE_HALF) >>> (ACC_FRAC - ANGLE_FRAC_BITS);
    clp = rnd;
    if (clp > ANGLE_FULL) clp = ANGLE_FULL;
    if (clp < -ANGLE_FULL) clp = -ANGLE_FULL;
    if (zero_r[CORDIC_STAGES]) begin
      clp = pos_r[CORDIC_STAGES] ? ANGLE_FULL :
            (neg_r[CORDIC_STAGES] ? -ANGLE_FULL : '0);
    end
    fin = clp;
    if (fin > OUT_MAX) fin = OUT_MAX;
    if (fin < OUT_MIN) fin = OUT_MIN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[CORDIC_STAGES];
    end
    if (en) begin
      angle_r <= fin[15:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_angle = angle_r;

endmodule

// ===== rtl/core/ata_checker.sv =====
module ata_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // A beat that was offered and not taken stays offered.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output beat dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output data changed while stalled");

  // An empty output never blocks the input side.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output is empty");

  // Both angles stay within plus or minus 90 degrees.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) <= 16'sd23040 &&
                    $signed(out_tdata[15:0]) >= -16'sd23040 &&
                    $signed(out_tdata[31:16]) <= 16'sd23040 &&
                    $signed(out_tdata[31:16]) >= -16'sd23040))
    else $error("angle out of range");

endmodule

bind accel_tilt_angles ata_checker u_ata_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
